// ----- src/tks_pkg.sv -----
package tks_pkg;

  localparam int CMD_W    = 2;
  localparam int NODE_W   = 16;
  localparam int SIM_W    = 16;
  localparam int SCORE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int K_W      = 5;

  localparam logic [K_W-1:0] K_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUMP_ITEM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0]         node;
    logic signed [SIM_W-1:0]   sim;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- src/tks_if.sv -----
interface tks_in_if;
  logic                                valid;
  logic                                ready;
  logic [tks_pkg::CMD_W-1:0]           cmd;
  logic [tks_pkg::NODE_W-1:0]          node_id;
  logic signed [tks_pkg::SIM_W-1:0]    similarity;
  logic signed [tks_pkg::SCORE_W-1:0]  score;

  modport source (output valid, cmd, node_id, similarity, score, input ready);
  modport sink (input valid, cmd, node_id, similarity, score, output ready);
endinterface

interface tks_out_if;
  logic                                valid;
  logic                                ready;
  logic [tks_pkg::STATUS_W-1:0]        status;
  logic [tks_pkg::NODE_W-1:0]          entry_node_id;
  logic signed [tks_pkg::SIM_W-1:0]    entry_similarity;
  logic signed [tks_pkg::SCORE_W-1:0]  entry_score;
  logic                                last;

  modport source (output valid, status, entry_node_id, entry_similarity, entry_score, last,
                  input ready);
  modport sink (input valid, status, entry_node_id, entry_similarity, entry_score, last,
                output ready);
endinterface

interface tks_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tks_pkg::K_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- src/tks_cell.sv -----
module tks_cell (
  input  logic                clk,
  input  tks_pkg::cell_ctrl_t ctrl,
  input  tks_pkg::entry_t     nb_d,
  input  tks_pkg::entry_t     ld_d,
  output tks_pkg::entry_t     q
);

  tks_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      entry_r <= ld_d;
    end else if (ctrl.shift) begin
      entry_r <= nb_d;
    end else begin
      entry_r <= entry_r;
    end
  end

  assign q = entry_r;

endmodule

// ----- src/top_k_score_keeper.sv -----
// Top-k score keeper: holds the SLOTS best (node, similarity, score) entries.
// in_ch carries requests: insert a candidate, dump the table, or clear it.
// out_ch returns results; last marks the final result of a request.
// cfg_ch writes k_in_use (always ready; write only while the block is idle).
// Entries sit in a ring of cells. A replace-path insert rotates the ring
// once past cell 0 to find the lowest score (lowest slot on ties), passing
// through S_SCAN, S_WRITE and S_RESP before the next request is accepted.
// An append passes through S_WRITE and S_RESP, an empty dump or a clear
// through S_RESP only. A dump rotates the ring once, emitting one entry per
// cycle for held slots while out_ch does not stall.
// One request is worked on at a time. Every result, including each dumped
// entry, is registered in the output register before it appears on out_ch.
// While out_ch.ready is low the result register holds and the dump rotation
// pauses; the ring always returns to slot order after a full turn.
// Reset empties the table and sets k_in_use to 16; slot contents are not
// cleared since only held slots are ever reported.
module top_k_score_keeper #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  tks_in_if.sink           in_ch,
  tks_out_if.source        out_ch,
  tks_cfg_if.sink          cfg_ch
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > tks_pkg::K_W) ? CW : tks_pkg::K_W;

  tks_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]              held_r;
  logic [tks_pkg::K_W-1:0]    k_r;
  logic [IW-1:0]              step_r;
  logic                       append_r;
  logic [tks_pkg::STATUS_W-1:0] status_r;
  tks_pkg::entry_t            cand_r;
  logic signed [tks_pkg::SCORE_W-1:0] min_score_r;
  logic [IW-1:0]              min_idx_r;

  logic                       out_valid_r;
  logic [tks_pkg::STATUS_W-1:0] out_status_r;
  tks_pkg::entry_t            out_entry_r;
  logic                       out_last_r;

  tks_pkg::entry_t            cell_q [SLOTS];
  logic                       shift;
  logic                       wr_en;
  logic [IW-1:0]              wr_idx;
  logic                       in_rdy;
  logic                       in_acc;
  logic                       advance;
  logic                       out_load;
  logic                       load_entry;
  logic                       last_nxt;
  logic [tks_pkg::STATUS_W-1:0] ostat;
  logic                       step_held;
  logic                       step_end;
  logic                       take;
  logic                       win;
  logic                       has_room;
  logic [CMPW-1:0]            k_ext;
  logic [CMPW-1:0]            cap;

  // ring of cells, each takes its right neighbor's entry on a shift
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      tks_pkg::cell_ctrl_t ctrl;
      assign ctrl.shift = shift;
      assign ctrl.load  = wr_en && (wr_idx == IW'(gi));
      tks_cell u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .nb_d (cell_q[(gi + 1) % SLOTS]),
        .ld_d (cand_r),
        .q    (cell_q[gi])
      );
    end
  endgenerate

  // capacity saturated into 1..SLOTS
  always_comb begin
    k_ext = CMPW'(k_r);
    priority if (k_ext == '0) begin
      cap = CMPW'(1);
    end else if (k_ext > CMPW'(SLOTS)) begin
      cap = CMPW'(SLOTS);
    end else begin
      cap = k_ext;
    end
  end

  assign has_room  = CMPW'(held_r) < cap;
  assign advance   = !out_valid_r || out_ch.ready;
  assign in_acc    = in_rdy && in_ch.valid;
  assign step_held = CW'(step_r) < held_r;
  assign step_end  = step_r == IW'(SLOTS - 1);
  assign take      = step_held && ((step_r == '0) || (cell_q[0].score < min_score_r));
  assign win       = min_score_r < cand_r.score;
  assign wr_idx    = append_r ? held_r[IW-1:0] : min_idx_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tks_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.cmd)
            tks_pkg::CMD_INSERT: state_nxt = has_room ? tks_pkg::S_WRITE : tks_pkg::S_SCAN;
            tks_pkg::CMD_DUMP:   state_nxt = (held_r == '0) ? tks_pkg::S_RESP : tks_pkg::S_DUMP;
            tks_pkg::CMD_CLEAR:  state_nxt = tks_pkg::S_RESP;
            default:             state_nxt = tks_pkg::S_IDLE;
          endcase
        end
      end
      tks_pkg::S_SCAN:  if (step_end) state_nxt = tks_pkg::S_WRITE;
      tks_pkg::S_WRITE: state_nxt = tks_pkg::S_RESP;
      tks_pkg::S_DUMP:  if (advance && step_end) state_nxt = tks_pkg::S_IDLE;
      tks_pkg::S_RESP:  if (advance) state_nxt = tks_pkg::S_IDLE;
      default:          state_nxt = tks_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_rdy     = 1'b0;
    shift      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    load_entry = 1'b0;
    last_nxt   = 1'b1;
    ostat      = status_r;
    unique case (state_r)
      tks_pkg::S_IDLE:  in_rdy = 1'b1;
      tks_pkg::S_SCAN:  shift = 1'b1;
      tks_pkg::S_WRITE: wr_en = append_r || win;
      tks_pkg::S_DUMP: begin
        shift      = advance;
        out_load   = advance && step_held;
        load_entry = 1'b1;
        ostat      = tks_pkg::ST_DUMP_ITEM;
        last_nxt   = CW'(step_r) == (held_r - CW'(1));
      end
      tks_pkg::S_RESP:  out_load = advance;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tks_pkg::S_IDLE;
      held_r      <= '0;
      k_r         <= tks_pkg::K_RESET;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        k_r <= cfg_ch.data;
      end
      if (in_acc) begin
        step_r <= '0;
        if (in_ch.cmd == tks_pkg::CMD_CLEAR) begin
          held_r <= '0;
        end
      end else if (shift) begin
        step_r <= step_r + IW'(1);
      end
      if (state_r == tks_pkg::S_WRITE && append_r) begin
        held_r <= held_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cand_r.node  <= in_ch.node_id;
      cand_r.sim   <= in_ch.similarity;
      cand_r.score <= in_ch.score;
      append_r     <= has_room;
      status_r     <= (in_ch.cmd == tks_pkg::CMD_CLEAR) ? tks_pkg::ST_CLEARED
                                                        : tks_pkg::ST_EMPTY;
    end
    if (state_r == tks_pkg::S_SCAN && take) begin
      min_score_r <= cell_q[0].score;
      min_idx_r   <= step_r;
    end
    if (state_r == tks_pkg::S_WRITE) begin
      status_r <= append_r ? tks_pkg::ST_APPENDED :
                  win      ? tks_pkg::ST_REPLACED : tks_pkg::ST_REJECTED;
    end
    if (out_load) begin
      out_status_r <= ostat;
      out_entry_r  <= load_entry ? cell_q[0] : '0;
      out_last_r   <= last_nxt;
    end
  end

  assign in_ch.ready             = in_rdy;
  assign cfg_ch.ready            = 1'b1;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.entry_node_id    = out_entry_r.node;
  assign out_ch.entry_similarity = out_entry_r.sim;
  assign out_ch.entry_score      = out_entry_r.score;
  assign out_ch.last             = out_last_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(SLOTS))
    else $error("held count above slot count");

  a_no_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(shift && wr_en))
    else $error("ring shift and slot write in the same cycle");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tks_pkg::S_SCAN |-> held_r != '0)
    else $error("minimum search over an empty table");

  a_dump_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == tks_pkg::CMD_DUMP && held_r != '0) |=>
      state_r == tks_pkg::S_DUMP && step_r == '0)
    else $error("dump request did not start the ring rotation");

  a_append_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tks_pkg::S_WRITE && append_r) |-> held_r < CW'(SLOTS))
    else $error("append past the last slot");

endmodule

// ----- bench/top_k_score_keeper_test.sv -----
`timescale 1ns / 100ps

module top_k_score_keeper_test;

  localparam int SLOTS = 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [tks_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [tks_pkg::STATUS_W-1:0]        status;
    logic [tks_pkg::NODE_W-1:0]          node;
    logic signed [tks_pkg::SIM_W-1:0]    sim;
    logic signed [tks_pkg::SCORE_W-1:0]  score;
    logic                                last;
  } result_t;

  logic clk;
  logic rst_n;

  tks_in_if  in_ch();
  tks_out_if out_ch();
  tks_cfg_if cfg_ch();

  top_k_score_keeper #(.SLOTS(SLOTS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the table
  logic [tks_pkg::K_W-1:0]            k_shadow;
  int unsigned                        held;
  logic [tks_pkg::NODE_W-1:0]         tbl_node  [SLOTS];
  logic signed [tks_pkg::SIM_W-1:0]   tbl_sim   [SLOTS];
  logic signed [tks_pkg::SCORE_W-1:0] tbl_score [SLOTS];

  result_t awaited_results[$];

  int fail_count;
  int request_count;
  int result_count;
  int dump_entries;
  int replace_count;
  int reject_count;
  int k_writes;
  int sender_idle_pct;
  int receiver_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void push_result(logic [tks_pkg::STATUS_W-1:0] status,
                                      logic [tks_pkg::NODE_W-1:0] node,
                                      logic signed [tks_pkg::SIM_W-1:0] sim,
                                      logic signed [tks_pkg::SCORE_W-1:0] score,
                                      logic last);
    result_t r;
    r.status = status;
    r.node   = node;
    r.sim    = sim;
    r.score  = score;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_request(logic [tks_pkg::CMD_W-1:0] cmd,
                                        logic [tks_pkg::NODE_W-1:0] node,
                                        logic signed [tks_pkg::SIM_W-1:0] sim,
                                        logic signed [tks_pkg::SCORE_W-1:0] score);
    int unsigned cap;
    int unsigned low_slot;
    cap = (k_shadow == 0) ? 1 : ((k_shadow > SLOTS) ? SLOTS : k_shadow);
    case (cmd)
      tks_pkg::CMD_INSERT: begin
        request_count++;
        if (held < cap) begin
          tbl_node[held]  = node;
          tbl_sim[held]   = sim;
          tbl_score[held] = score;
          held++;
          push_result(tks_pkg::ST_APPENDED, '0, '0, '0, 1'b1);
        end else begin
          // held can exceed cap after k is lowered; minimum is over all held slots
          low_slot = 0;
          for (int unsigned i = 1; i < held; i++)
            if (tbl_score[i] < tbl_score[low_slot]) low_slot = i;
          if (tbl_score[low_slot] < score) begin
            tbl_node[low_slot]  = node;
            tbl_sim[low_slot]   = sim;
            tbl_score[low_slot] = score;
            replace_count++;
            push_result(tks_pkg::ST_REPLACED, '0, '0, '0, 1'b1);
          end else begin
            reject_count++;
            push_result(tks_pkg::ST_REJECTED, '0, '0, '0, 1'b1);
          end
        end
      end
      tks_pkg::CMD_DUMP: begin
        request_count++;
        if (held == 0) begin
          push_result(tks_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < held; i++) begin
            dump_entries++;
            push_result(tks_pkg::ST_DUMP_ITEM, tbl_node[i], tbl_sim[i], tbl_score[i],
                        i + 1 == held);
          end
        end
      end
      tks_pkg::CMD_CLEAR: begin
        request_count++;
        held = 0;
        push_result(tks_pkg::ST_CLEARED, '0, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (awaited_results.size() == 0) begin
        $error("result with nothing pending: status=%0d node=%0h last=%0b",
               out_ch.status, out_ch.entry_node_id, out_ch.last);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.entry_node_id !== want.node) begin
          $error("entry_node_id: expected %0h, got %0h", want.node, out_ch.entry_node_id);
          fail_count++;
        end
        if (out_ch.entry_similarity !== want.sim) begin
          $error("entry_similarity: expected %0d, got %0d", want.sim, out_ch.entry_similarity);
          fail_count++;
        end
        if (out_ch.entry_score !== want.score) begin
          $error("entry_score: expected %0d, got %0d", want.score, out_ch.entry_score);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (receiver_stall_pct == 0) out_ch.ready = 1'b1;
    else out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_request(logic [tks_pkg::CMD_W-1:0] cmd,
                              logic [tks_pkg::NODE_W-1:0] node,
                              logic signed [tks_pkg::SIM_W-1:0] sim,
                              logic signed [tks_pkg::SCORE_W-1:0] score);
    @(negedge clk);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.cmd        = cmd;
    in_ch.node_id    = node;
    in_ch.similarity = sim;
    in_ch.score      = score;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(cmd, node, sim, score);
  endtask

  // drop valid, wait for every pending result, then let an ignored request settle
  task automatic drain();
    int c;
    @(negedge clk);
    in_ch.valid = 1'b0;
    c = 0;
    while (awaited_results.size() != 0 && c < DRAIN_LIMIT) begin
      @(posedge clk);
      c++;
    end
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
      awaited_results.delete();
    end
    repeat (SLOTS + 6) @(posedge clk);
  endtask

  task automatic write_k(logic [tks_pkg::K_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    k_shadow = value;
    k_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic signed [tks_pkg::SCORE_W-1:0] pick_score();
    logic signed [tks_pkg::SCORE_W-1:0] s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: s = 32'sh8000_0000;
          1: s = 32'sh7FFF_FFFF;
          2: s = '0;
          default: s = -1;
        endcase
      end
      // narrow band so ties and rejects come up often
      1, 2, 3: s = $signed($urandom_range(8)) - 4;
      default: s = $urandom;
    endcase
    return s;
  endfunction

  function automatic logic [tks_pkg::K_W-1:0] pick_k();
    logic [tks_pkg::K_W-1:0] k;
    case ($urandom_range(7))
      0: k = 5'd0;
      1: k = 5'd1;
      2: k = 5'd16;
      3: k = 5'd31;
      default: k = tks_pkg::K_W'($urandom_range(31));
    endcase
    return k;
  endfunction

  task automatic test_empty_table();
    send_request(tks_pkg::CMD_DUMP, '0, '0, '0);
    send_request(tks_pkg::CMD_CLEAR, '0, '0, '0);
    send_request(CMD_UNUSED, 16'hFFFF, -1, -1);
    drain();
  endtask

  task automatic test_field_extremes();
    send_request(tks_pkg::CMD_INSERT, 16'hFFFF, 16'sh8000, 32'sh8000_0000);
    send_request(tks_pkg::CMD_INSERT, 16'h0000, 16'sh7FFF, 32'sh7FFF_FFFF);
    send_request(tks_pkg::CMD_INSERT, 16'h5A5A, 16'sh0000, 32'sh0000_0000);
    send_request(tks_pkg::CMD_INSERT, 16'hA5A5, -16'sd1, -32'sd1);
    send_request(tks_pkg::CMD_DUMP, '0, '0, '0);
    send_request(tks_pkg::CMD_CLEAR, '0, '0, '0);
  endtask

  task automatic test_ties_and_rejects();
    write_k(5'd2);
    send_request(tks_pkg::CMD_INSERT, 16'h0101, 16'sh1111, 32'sd5);
    send_request(tks_pkg::CMD_INSERT, 16'h0202, 16'sh2222, 32'sd5);
    // equal score is not strictly greater
    send_request(tks_pkg::CMD_INSERT, 16'h0303, 16'sh3333, 32'sd5);
    // tie on minimum: lowest slot is replaced
    send_request(tks_pkg::CMD_INSERT, 16'h0404, 16'sh4444, 32'sd6);
    send_request(tks_pkg::CMD_INSERT, 16'h0505, 16'sh5555, 32'sh8000_0000);
    send_request(tks_pkg::CMD_DUMP, '0, '0, '0);
  endtask

  task automatic test_capacity_limits();
    // zero acts as one; table stays at two entries
    write_k(5'd0);
    send_request(tks_pkg::CMD_INSERT, 16'h0606, 16'sh6666, 32'sd7);
    send_request(tks_pkg::CMD_DUMP, '0, '0, '0);
    send_request(tks_pkg::CMD_CLEAR, '0, '0, '0);
    send_request(tks_pkg::CMD_INSERT, 16'h0707, 16'sh7777, -32'sd3);
    send_request(tks_pkg::CMD_INSERT, 16'h0808, 16'sh0808, 32'sd9);
    send_request(tks_pkg::CMD_INSERT, 16'h0909, 16'sh0909, 32'sd8);
    // above the slot count saturates
    write_k(5'd31);
    send_request(tks_pkg::CMD_INSERT, 16'h0A0A, 16'sh0A0A, 32'sd1);
    send_request(tks_pkg::CMD_DUMP, '0, '0, '0);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int sent;
    int next_cfg;
    int pick;
    logic [tks_pkg::CMD_W-1:0] cmd;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent     = 0;
    next_cfg = 0;
    while (sent < n_items) begin
      if (sent >= next_cfg) begin
        write_k(pick_k());
        next_cfg = sent + int'($urandom_range(50, 25));
      end
      pick = int'($urandom_range(99));
      if (pick < 74) cmd = tks_pkg::CMD_INSERT;
      else if (pick < 88) cmd = tks_pkg::CMD_DUMP;
      else if (pick < 96) cmd = tks_pkg::CMD_CLEAR;
      else cmd = CMD_UNUSED;
      send_request(cmd, tks_pkg::NODE_W'($urandom), tks_pkg::SIM_W'($urandom),
                   pick_score());
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = tks_pkg::CMD_INSERT;
    in_ch.node_id      = '0;
    in_ch.similarity   = '0;
    in_ch.score        = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    k_shadow           = tks_pkg::K_RESET;
    held               = 0;
    fail_count         = 0;
    request_count      = 0;
    result_count       = 0;
    dump_entries       = 0;
    replace_count      = 0;
    reject_count       = 0;
    k_writes           = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_field_extremes();
    test_ties_and_rejects();
    test_capacity_limits();
    test_random_traffic(0, 0, 108);
    test_random_traffic(87, 0, 108);
    test_random_traffic(0, 87, 108);
    test_random_traffic(16, 16, 108);
    drain();

    $display("run covered %0d requests, %0d results checked, %0d capacity writes",
             request_count, result_count, k_writes);
    $display("  %0d dumped entries, %0d replacements, %0d rejections",
             dump_entries, replace_count, reject_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
